// ----- rtl/btc_pkg.sv -----
package btc_pkg;

   localparam logic [2:0] CMD_PRESS   = 3'd0;
   localparam logic [2:0] CMD_HOLD    = 3'd1;
   localparam logic [2:0] CMD_RELEASE = 3'd2;
   localparam logic [2:0] CMD_TICK    = 3'd3;
   localparam logic [2:0] CMD_AGENT   = 3'd4;

   localparam logic [3:0] ACT_NONE      = 4'd0;
   localparam logic [3:0] ACT_COUNTDOWN = 4'd1;
   localparam logic [3:0] ACT_RESET     = 4'd2;
   localparam logic [3:0] ACT_PAGE      = 4'd3;
   localparam logic [3:0] ACT_ENCODER   = 4'd4;
   localparam logic [3:0] ACT_SEND      = 4'd5;
   localparam logic [3:0] ACT_ADVERTISE = 4'd6;
   localparam logic [3:0] ACT_AGENT     = 4'd7;
   localparam logic [3:0] ACT_COMMAND   = 4'd8;

   localparam logic [1:0] CSR_LONG_PRESS = 2'd0;
   localparam logic [1:0] CSR_DOUBLE_TAP = 2'd1;
   localparam logic [1:0] CSR_WARN_HOLD  = 2'd2;

   localparam logic [15:0] LONG_PRESS_RESET = 16'd550;
   localparam logic [15:0] DOUBLE_TAP_RESET = 16'd350;
   localparam logic [15:0] WARN_HOLD_RESET  = 16'd3000;

   localparam logic [31:0] RESET_HOLD_MS    = 32'd20000;
   localparam logic [4:0]  COUNTDOWN_FULL_S = 5'd20;
   localparam logic [6:0]  PROGRESS_MAX     = 7'd100;
   localparam logic [2:0]  NUM_KEYS         = 3'd6;

   // held/1000 = (held>>3)/125 and held/200 = (held>>3)/25 via reciprocals,
   // exact for held below 32768
   localparam logic [13:0] RECIP_125 = 14'd8389;
   localparam int          SHIFT_125 = 20;
   localparam logic [11:0] RECIP_25  = 12'd2622;
   localparam int          SHIFT_25  = 16;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] now_ms;
      logic        connected;
      logic [2:0]  agent_index;
   } req_item_type;

   typedef struct packed {
      logic [3:0] action;
      logic [4:0] countdown_s;
      logic [6:0] progress;
      logic [2:0] key_index;
      logic       page_mode;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] long_press_ms;
      logic [15:0] double_tap_ms;
      logic [15:0] warn_hold_ms;
   } cfg_type;

   typedef struct packed {
      logic       warn;
      logic       fire;
      logic [4:0] countdown_s;
      logic [6:0] progress;
   } hold_info_type;

endpackage

// ----- rtl/btc_if.sv -----
interface btc_req_if import btc_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [2:0] cmd;
   logic [31:0] now_ms;
   logic       connected;
   logic [2:0] agent_index;

   modport source (output valid, cmd, now_ms, connected, agent_index, input ready);
   modport sink (input valid, cmd, now_ms, connected, agent_index, output ready);
endinterface

interface btc_rsp_if import btc_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [3:0] action;
   logic [4:0] countdown_s;
   logic [6:0] progress;
   logic [2:0] key_index;
   logic       page_mode;

   modport source (output valid, action, countdown_s, progress, key_index, page_mode,
                   input ready);
   modport sink (input valid, action, countdown_s, progress, key_index, page_mode,
                 output ready);
endinterface

// ----- rtl/button_tap_hold_classifier_unit.sv -----
// Center-button gesture classifier.
// req: one beat per touch event (cmd, now_ms, connected, agent_index);
//   a beat is taken when valid and ready are both high.
// rsp: exactly one beat per req beat, in order (action, countdown_s,
//   progress, key_index, page_mode).
// csr: csr_we writes csr_wdata[15:0] to register csr_index at the clock
//   edge (0 long press, 1 double tap window, 2 warn hold); write only
//   while idle. Other indexes are ignored.
// A req beat taken into the input register passes the single classify
//   pass and is offered on rsp from the result register. Throughput: one
//   beat per cycle while rsp.ready is high, set by that single pass.
// Stall: the result register holds while rsp.ready is low; one more beat
//   is taken into the input register, then req.ready drops until the
//   result drains.
// Reset (synchronous, active high): both registers empty, gesture state
//   cleared to the normal page, registers back to 550/350/3000 ms.
module button_tap_hold_classifier_unit import btc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   btc_req_if.sink      req,
   btc_rsp_if.source    rsp,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   req_item_type req_item_ff;
   logic         req_valid_ff, req_valid_in;
   rsp_item_type rsp_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   cfg_type      cfg_ff;
   rsp_item_type result;
   logic         rsp_open;
   logic         advance;
   logic         req_take;

   always_comb begin
      rsp_open     = !rsp_valid_ff || rsp.ready;
      advance      = req_valid_ff && rsp_open;
      req.ready    = !req_valid_ff || advance;
      req_take     = req.valid && req.ready;
      req_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : req_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
   end

   btc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (req_item_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_item_ff.cmd         <= req.cmd;
         req_item_ff.now_ms      <= req.now_ms;
         req_item_ff.connected   <= req.connected;
         req_item_ff.agent_index <= req.agent_index;
      end
      if (advance) begin
         rsp_item_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_ms <= LONG_PRESS_RESET;
         cfg_ff.double_tap_ms <= DOUBLE_TAP_RESET;
         cfg_ff.warn_hold_ms  <= WARN_HOLD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LONG_PRESS: cfg_ff.long_press_ms <= csr_wdata;
            CSR_DOUBLE_TAP: cfg_ff.double_tap_ms <= csr_wdata;
            CSR_WARN_HOLD:  cfg_ff.warn_hold_ms  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.action      = rsp_item_ff.action;
   assign rsp.countdown_s = rsp_item_ff.countdown_s;
   assign rsp.progress    = rsp_item_ff.progress;
   assign rsp.key_index   = rsp_item_ff.key_index;
   assign rsp.page_mode   = rsp_item_ff.page_mode;

   reset_result_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.action == ACT_RESET
      |-> rsp_item_ff.countdown_s == 5'd0 && rsp_item_ff.progress == PROGRESS_MAX)
      else $error("factory reset beat without full progress");

   hold_fields_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.action != ACT_COUNTDOWN && rsp_item_ff.action != ACT_RESET
      |-> rsp_item_ff.countdown_s == 5'd0 && rsp_item_ff.progress == 7'd0)
      else $error("countdown fields set on a non-hold beat");

   key_fields_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.action != ACT_AGENT && rsp_item_ff.action != ACT_COMMAND
      |-> rsp_item_ff.key_index == 3'd0)
      else $error("key index set on a non-key beat");

   stalled_item_held: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !advance |=> req_valid_ff && $stable(req_item_ff))
      else $error("stalled input beat lost");

endmodule

// ----- rtl/btc_hold.sv -----
module btc_hold import btc_pkg::*; (
   input  logic [31:0]   held,
   input  logic [15:0]   warn_hold_ms,
   output hold_info_type info
);

   logic [11:0] eighths;
   logic [25:0] secs_prod;
   logic [23:0] prog_prod;
   logic [4:0]  secs;
   logic [6:0]  pct;

   always_comb begin
      eighths   = held[14:3];
      secs_prod = {14'd0, eighths} * {12'd0, RECIP_125};
      prog_prod = {12'd0, eighths} * {12'd0, RECIP_25};
      secs      = secs_prod[SHIFT_125 +: 5];
      pct       = prog_prod[SHIFT_25 +: 7];

      info.fire = held >= RESET_HOLD_MS;
      info.warn = held >= {16'd0, warn_hold_ms};
      if (info.fire) begin
         info.countdown_s = '0;
         info.progress    = PROGRESS_MAX;
      end else begin
         info.countdown_s = COUNTDOWN_FULL_S - secs;
         info.progress    = pct;
      end
   end

endmodule

// ----- rtl/btc_core.sv -----
module btc_core import btc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   logic [31:0]   press_time_ff, press_time_in;
   logic          reset_latched_ff, reset_latched_in;
   logic          tap_pending_ff, tap_pending_in;
   logic [31:0]   tap_time_ff, tap_time_in;
   logic          command_page_ff, command_page_in;
   logic [31:0]   held;
   logic [31:0]   tap_age;
   hold_info_type hold_info;

   btc_hold u_hold (
      .held         (held),
      .warn_hold_ms (cfg.warn_hold_ms),
      .info         (hold_info)
   );

   always_comb begin
      held             = item.now_ms - press_time_ff;
      tap_age          = item.now_ms - tap_time_ff;
      press_time_in    = press_time_ff;
      reset_latched_in = reset_latched_ff;
      tap_pending_in   = tap_pending_ff;
      tap_time_in      = tap_time_ff;
      command_page_in  = command_page_ff;
      result           = '0;
      result.action    = ACT_NONE;

      case (item.cmd)
         CMD_PRESS: begin
            press_time_in    = item.now_ms;
            reset_latched_in = 1'b0;
         end
         CMD_HOLD: begin
            if (!reset_latched_ff) begin
               if (hold_info.warn || hold_info.fire) begin
                  result.action      = ACT_COUNTDOWN;
                  result.countdown_s = hold_info.countdown_s;
                  result.progress    = hold_info.progress;
               end
               if (hold_info.fire) begin
                  reset_latched_in = 1'b1;
                  result.action    = ACT_RESET;
               end
            end
         end
         CMD_RELEASE: begin
            if (!reset_latched_ff) begin
               if (held >= {16'd0, cfg.long_press_ms}) begin
                  command_page_in = !command_page_ff;
                  result.action   = ACT_PAGE;
               end else if (command_page_ff) begin
                  result.action = ACT_ENCODER;
               end else if (tap_pending_ff && tap_age <= {16'd0, cfg.double_tap_ms}) begin
                  tap_pending_in = 1'b0;
                  result.action  = item.connected ? ACT_SEND : ACT_ADVERTISE;
               end else begin
                  tap_pending_in = 1'b1;
                  tap_time_in    = item.now_ms;
               end
            end
         end
         CMD_TICK: begin
            if (tap_pending_ff && tap_age > {16'd0, cfg.double_tap_ms}) begin
               tap_pending_in = 1'b0;
               if (item.connected) begin
                  result.action = ACT_SEND;
               end
            end
         end
         CMD_AGENT: begin
            if (item.agent_index < NUM_KEYS) begin
               result.action    = command_page_ff ? ACT_COMMAND : ACT_AGENT;
               result.key_index = item.agent_index;
            end
         end
         default: begin
         end
      endcase

      result.page_mode = command_page_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_time_ff    <= '0;
         reset_latched_ff <= 1'b0;
         tap_pending_ff   <= 1'b0;
         tap_time_ff      <= '0;
         command_page_ff  <= 1'b0;
      end else if (advance) begin
         press_time_ff    <= press_time_in;
         reset_latched_ff <= reset_latched_in;
         tap_pending_ff   <= tap_pending_in;
         tap_time_ff      <= tap_time_in;
         command_page_ff  <= command_page_in;
      end
   end

   tap_time_follows_arm: assert property (@(posedge clock) disable iff (reset)
      advance && item.cmd == CMD_RELEASE && result.action == ACT_NONE && !reset_latched_ff
      |=> tap_pending_ff && tap_time_ff == $past(item.now_ms))
      else $error("armed tap lost its time stamp");

   latch_blocks_release: assert property (@(posedge clock) disable iff (reset)
      advance && reset_latched_ff && item.cmd == CMD_RELEASE
      |=> $stable(command_page_ff) && $stable(tap_pending_ff))
      else $error("latched release changed state");

   press_clears_latch: assert property (@(posedge clock) disable iff (reset)
      advance && item.cmd == CMD_PRESS |=> !reset_latched_ff)
      else $error("press left reset latch set");

endmodule
